@@ src/fmpr_pkg.sv @@
package fmpr_pkg;

  localparam int ModBits   = 30;
  localparam int EntryBits = 31;
  localparam int ProdBits  = 62;
  localparam int SumBits   = 63;

  typedef logic [EntryBits-1:0] entry_t;
  typedef logic [ModBits-1:0]   mod_t;
  typedef logic [SumBits-1:0]   sum_t;

  typedef struct packed {
    entry_t e00;
    entry_t e01;
    entry_t e10;
    entry_t e11;
  } mat_t;

endpackage

@@ src/fmpr_if.sv @@
interface fmpr_in_if;
  import fmpr_pkg::*;
  logic        valid;
  logic        ready;
  logic [62:0] exponent;
  mod_t        modulus;
  modport source (output valid, exponent, modulus, input ready);
  modport sink (input valid, exponent, modulus, output ready);
endinterface

interface fmpr_out_if;
  import fmpr_pkg::*;
  logic   valid;
  logic   ready;
  entry_t entry_00;
  entry_t entry_01;
  entry_t entry_10;
  entry_t entry_11;
  modport source (output valid, entry_00, entry_01, entry_10, entry_11, input ready);
  modport sink (input valid, entry_00, entry_01, entry_10, entry_11, output ready);
endinterface

@@ src/fmpr_reduce.sv @@
// Sequential x mod m, one quotient bit per cycle (restoring division),
// then the "x > m ? x mod m + m : x" rule.
module fmpr_reduce
  import fmpr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  sum_t   x,
  input  mod_t   m,
  output logic   done,
  output entry_t result
);

  localparam int CntBits = $clog2(SumBits + 1);

  logic [ModBits:0]   rem;
  sum_t               val;
  sum_t               orig;
  logic [CntBits-1:0] cnt;
  logic               busy;
  logic [ModBits+1:0] trial;

  always_comb begin
    trial = {rem, val[SumBits-1]} - {2'b00, m};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        val  <= x;
        orig <= x;
        cnt  <= CntBits'(SumBits);
      end else if (busy) begin
        if (!trial[ModBits+1]) rem <= trial[ModBits:0];
        else rem <= {rem[ModBits-1:0], val[SumBits-1]};
        val <= {val[SumBits-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // rem < m < 2^30, so rem + m fits in 31 bits
  always_comb begin
    if (orig > {{(SumBits-ModBits){1'b0}}, m})
      result = EntryBits'(rem) + EntryBits'(m);
    else
      result = orig[EntryBits-1:0];
  end

endmodule

@@ src/fibonacci_matrix_power_reduced_core.sv @@
// Each exponent bit takes one matrix squaring, plus a product into the
// accumulator first when that bit is set. Each matrix product computes
// 4 entries, each by two multiply steps, a reducer start and a bit-serial reduce.
// One transaction at a time; not ready while busy.
// Synchronous active-high reset returns the sequencer to idle.
module fibonacci_matrix_power_reduced_core
  import fmpr_pkg::*;
#(
  parameter int EXP_BITS = 63
) (
  input logic clk,
  input logic rst,
  fmpr_in_if.sink    in_ch,
  fmpr_out_if.source out_ch
);

  localparam int BitCnt = $clog2(EXP_BITS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL0 = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_ADD  = 7'b0001000,
    S_RED  = 7'b0010000,
    S_NEXT = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t              state;
  logic [EXP_BITS-1:0] expo;
  mod_t                m;
  mat_t                acc, base, prod;
  logic                sq;        // 1: base*base, 0: acc*base
  logic [1:0]          idx;       // entry index r*2+k
  logic [BitCnt-1:0]   bitn;
  logic [ProdBits-1:0] p0;
  logic [ProdBits-1:0] mul_out;
  entry_t              ma, mb;
  sum_t                sum;
  logic                red_start, red_done;
  entry_t              red_res;

  function automatic entry_t get(input mat_t x, input logic [1:0] i);
    entry_t r;
    case (i)
      2'd0:    r = x.e00;
      2'd1:    r = x.e01;
      2'd2:    r = x.e10;
      default: r = x.e11;
    endcase
    return r;
  endfunction

  // a[r][j] * b[j][k]; j is 0 in S_MUL0 and 1 in S_MUL1
  always_comb begin
    logic j;
    mat_t a;
    j  = (state == S_MUL1);
    a  = sq ? base : acc;
    ma = get(a, {idx[1], j});
    mb = get(base, {j, idx[0]});
    mul_out = ProdBits'(ma) * ProdBits'(mb);
  end

  assign red_start = (state == S_ADD);

  fmpr_reduce u_red (
    .clk    (clk),
    .rst    (rst),
    .start  (red_start),
    .x      (sum),
    .m      (m),
    .done   (red_done),
    .result (red_res)
  );

  assign in_ch.ready     = (state == S_IDLE);
  assign out_ch.valid    = (state == S_OUT);
  assign out_ch.entry_00 = acc.e00;
  assign out_ch.entry_01 = acc.e01;
  assign out_ch.entry_10 = acc.e10;
  assign out_ch.entry_11 = acc.e11;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            expo  <= in_ch.exponent[EXP_BITS-1:0];
            m     <= (in_ch.modulus == '0) ? mod_t'(1) : in_ch.modulus;
            acc   <= '{e00: entry_t'(1), e01: '0, e10: '0, e11: entry_t'(1)};
            base  <= '{e00: entry_t'(1), e01: entry_t'(1), e10: entry_t'(1), e11: '0};
            bitn  <= '0;
            idx   <= '0;
            sq    <= ~in_ch.exponent[0];
            state <= S_MUL0;
          end
        end
        S_MUL0: begin
          p0    <= mul_out;
          state <= S_MUL1;
        end
        S_MUL1: begin
          sum   <= SumBits'(p0) + SumBits'(mul_out);
          state <= S_ADD;
        end
        S_ADD: state <= S_RED;
        S_RED: begin
          if (red_done) begin
            case (idx)
              2'd0:    prod.e00 <= red_res;
              2'd1:    prod.e01 <= red_res;
              2'd2:    prod.e10 <= red_res;
              default: prod.e11 <= red_res;
            endcase
            idx <= idx + 2'd1;
            state <= (idx == 2'd3) ? S_NEXT : S_MUL0;
          end
        end
        S_NEXT: begin
          idx <= '0;
          if (!sq) begin
            acc   <= prod;
            sq    <= 1'b1;
            state <= S_MUL0;
          end else begin
            base <= prod;
            if (bitn == BitCnt'(EXP_BITS - 1)) begin
              state <= S_OUT;
            end else begin
              bitn  <= bitn + 1'b1;
              sq    <= ~expo[bitn + 1'b1];
              state <= S_MUL0;
            end
          end
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/fibonacci_matrix_power_reduced_core_tb.sv @@
module fibonacci_matrix_power_reduced_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fmpr_pkg::*;

  typedef struct {
    logic [62:0] exponent;
    mod_t        modulus;
  } request_t;

  typedef longint unsigned u64_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fmpr_in_if  in_ch ();
  fmpr_out_if out_ch ();

  fibonacci_matrix_power_reduced_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  request_t pending_reqs[$];
  mat_t     expected_mats[$];
  int       mismatches = 0;
  int       burst_left = 0;
  int       gap_left   = 0;
  int       hold_left  = 0;
  int       results_seen = 0;
  bit       long_hold_done = 1'b0;

  // Reduction after each product: values above m become (x mod m) + m.
  function automatic u64_t fold_entry(u64_t x, u64_t m);
    if (x > m) begin
      return (x % m) + m;
    end
    return x;
  endfunction

  function automatic void mat_product(input u64_t a[4], input u64_t b[4], input u64_t m,
                                      output u64_t c[4]);
    c[0] = fold_entry(a[0] * b[0] + a[1] * b[2], m);
    c[1] = fold_entry(a[0] * b[1] + a[1] * b[3], m);
    c[2] = fold_entry(a[2] * b[0] + a[3] * b[2], m);
    c[3] = fold_entry(a[2] * b[1] + a[3] * b[3], m);
  endfunction

  function automatic mat_t fib_power(request_t req);
    u64_t  m;
    u64_t  base[4];
    u64_t  acc[4];
    u64_t  tmp[4];
    mat_t  res;
    m = u64_t'(req.modulus);
    if (m == 0) begin
      m = 1;
    end
    base = '{1, 1, 1, 0};
    acc  = '{1, 0, 0, 1};
    for (int b = 0; b < 63; b++) begin
      if (req.exponent[b]) begin
        mat_product(acc, base, m, tmp);
        acc = tmp;
      end
      mat_product(base, base, m, tmp);
      base = tmp;
    end
    res.e00 = acc[0][30:0];
    res.e01 = acc[1][30:0];
    res.e10 = acc[2][30:0];
    res.e11 = acc[3][30:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, entry_t got, entry_t want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic add_req(logic [62:0] e, mod_t m);
    request_t r;
    r.exponent = e;
    r.modulus  = m;
    pending_reqs.push_back(r);
  endtask

  // Sender: bursts with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid    <= 1'b0;
      in_ch.exponent <= '0;
      in_ch.modulus  <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        request_t r;
        r.exponent = in_ch.exponent;
        r.modulus  = in_ch.modulus;
        expected_mats.push_back(fib_power(r));
      end
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        request_t r;
        r = pending_reqs.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.exponent <= r.exponent;
        in_ch.modulus  <= r.modulus;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 6);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
  end

  // Receiver: random stall pattern, plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && results_seen == 20) begin
      long_hold_done = 1'b1;
      hold_left = 120000;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      hold_left = $urandom_range(0, 30);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_mats.size() == 0) begin
        $display("unexpected result transaction %0d", results_seen);
        mismatches++;
      end else begin
        mat_t want;
        want = expected_mats.pop_front();
        if (out_ch.entry_00 !== want.e00) report_mismatch("entry_00", out_ch.entry_00, want.e00);
        if (out_ch.entry_01 !== want.e01) report_mismatch("entry_01", out_ch.entry_01, want.e01);
        if (out_ch.entry_10 !== want.e10) report_mismatch("entry_10", out_ch.entry_10, want.e10);
        if (out_ch.entry_11 !== want.e11) report_mismatch("entry_11", out_ch.entry_11, want.e11);
      end
      results_seen++;
    end
  end

  initial begin
    logic [62:0] e;
    mod_t        m;
    // Directed: zero exponent, tiny and huge exponents, modulus extremes incl. zero.
    add_req(63'd0, 30'd7);
    add_req(63'd0, 30'd1);
    add_req(63'd1, 30'd1);
    add_req(63'd1, '1);
    add_req(63'd2, 30'd2);
    add_req(63'd10, '1);
    add_req(63'd45, '1);
    add_req(63'd50, 30'd1000);
    add_req('1, '1);
    add_req('1, 30'd1);
    add_req('1, 30'd0);
    add_req(63'd12, 30'd0);
    add_req(63'h4000_0000_0000_0000, 30'd3);
    add_req(63'h5555_5555_5555_5555, 30'h2AAA_AAAA);
    add_req(63'h2AAA_AAAA_AAAA_AAAA, 30'h1555_5555);
    add_req(63'd90, 30'd1_000_000_007);
    add_req(63'd3, 30'h2000_0000);
    add_req(63'h7FFF_FFFF_0000_0000, 30'd12345);
    for (int i = 0; i < 272; i++) begin
      e = 63'({$urandom, $urandom});
      case ($urandom_range(0, 3))
        0: e = e & 63'h3F;
        1: e = e >> $urandom_range(0, 62);
        default: ;
      endcase
      m = mod_t'($urandom);
      case ($urandom_range(0, 4))
        0: m = m & 30'hF;
        1: m = m >> $urandom_range(0, 29);
        2: m = ($urandom_range(0, 1) == 1) ? '1 : 30'd1;
        default: ;
      endcase
      add_req(e, m);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || in_ch.valid || expected_mats.size() != 0) begin
      @(posedge clk);
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_mats.size() == 0) begin
      $display("fibonacci_matrix_power_reduced_core_tb: PASS");
    end else begin
      $display("fibonacci_matrix_power_reduced_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000ms;
    $display("fibonacci_matrix_power_reduced_core_tb: FAIL");
    $finish;
  end

endmodule

@@ fibonacci_matrix_power_reduced_core.f @@
src/fmpr_pkg.sv
src/fmpr_if.sv
src/fmpr_reduce.sv
src/fibonacci_matrix_power_reduced_core.sv
tb/fibonacci_matrix_power_reduced_core_tb.sv
